[rtl/core/hetq_pkg.sv]
// Shared constants, types and codes of the heap event timer queue.
`timescale 1ns / 1ps
`default_nettype none

package hetq_pkg;

  // Heap size and the cap on expired items reported by one advance.
  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;

  // Field widths.
  localparam int DL_W      = 32;
  localparam int ID_W      = 16;
  localparam int AMT_W     = 16;
  localparam int CNT_OUT_W = 6;

  // Derived widths: slot index, entry count and pop counter.
  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POP_W = $clog2(MAX_RESULTS + 1);

  // One heap entry as stored in memory.
  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Command codes.
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_REJECTED = 2'd1,
    ST_EXPIRED  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_UP_PUT,
    S_EMIT,
    S_POP_RD,
    S_POP_CHK,
    S_POP_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR,
    S_DN_CMP,
    S_DN_PUT
  } state_t;

endpackage

`default_nettype wire

[rtl/core/hetq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hetq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/heap_event_timer_queue.sv]
// Top level of the heap event timer queue: sequencer, heap memory and output register.
//
// Usage:
//   The input channel (in_valid/in_ready, command, amount) takes one item at a
//   time. An add item inserts an event with deadline tick + amount (saturating),
//   or is rejected when the heap is full, and returns one result. An advance
//   item moves the tick forward and returns one result per expired event, in
//   (deadline, id) order, at most MAX_RESULTS, the final one flagged by last;
//   with nothing expired it returns one status result carrying the new tick.
//   Results leave on out_valid/out_ready through an output register.
//   An add compares the new entry with one parent at a time on its way up.
//   Each expired event of an advance moves the last entry to the root and sifts
//   it down one heap level at a time, paced by the single read port of the heap
//   memory, which is read once per compare.
//   in_ready is high only while the sequencer is idle; an item may be accepted
//   while the previous result still waits in the output register.
//   When the receiver stalls, the sequencer holds at the next result until the
//   output register frees up. Reset clears the count, the tick and the
//   output valid flag and sets the next id to 1; no memory sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module heap_event_timer_queue (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [hetq_pkg::AMT_W-1:0]      amount,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           status,
  output logic [hetq_pkg::ID_W-1:0]            event_id,
  output logic [hetq_pkg::DL_W-1:0]            deadline,
  output logic [hetq_pkg::CNT_OUT_W-1:0]       active_count,
  output logic                                 last
);

  localparam int PTR_W = hetq_pkg::PTR_W;
  localparam int CNT_W = hetq_pkg::CNT_W;
  localparam int POP_W = hetq_pkg::POP_W;
  localparam int DL_W  = hetq_pkg::DL_W;
  localparam int ID_W  = hetq_pkg::ID_W;
  localparam int IDX_W = PTR_W + 2;

  // Strict (deadline, id) ordering of two entries.
  function automatic logic entry_less(hetq_pkg::entry_t a, hetq_pkg::entry_t b);
    if (a.dl != b.dl) begin
      return a.dl < b.dl;
    end
    return a.id < b.id;
  endfunction

  // Count as reported on a result, saturated to the field width.
  function automatic logic [hetq_pkg::CNT_OUT_W-1:0] count_sat(logic [CNT_W-1:0] c);
    logic [CNT_W+6:0] wide;
    wide = (CNT_W + 7)'(c);
    if (wide > (CNT_W + 7)'(63)) begin
      return 6'd63;
    end
    return wide[hetq_pkg::CNT_OUT_W-1:0];
  endfunction

  hetq_pkg::state_t state, state_next;

  // Control and datapath registers.
  logic [CNT_W-1:0]         count;
  logic [DL_W-1:0]          tick;
  logic [ID_W-1:0]          next_id;
  logic [POP_W-1:0]         popped;
  logic [PTR_W-1:0]         pos;
  logic [PTR_W-1:0]         cidx;
  hetq_pkg::entry_t         mov;
  hetq_pkg::entry_t         cand;
  hetq_pkg::status_t        res_status;
  logic [ID_W-1:0]          res_id;
  logic [DL_W-1:0]          res_dl;
  logic [hetq_pkg::CNT_OUT_W-1:0] res_count;

  // Memory port signals.
  logic                     wr_en;
  logic [PTR_W-1:0]         wr_addr;
  hetq_pkg::entry_t         wr_data;
  logic                     rd_en;
  logic [PTR_W-1:0]         rd_addr;
  logic [hetq_pkg::ENTRY_W-1:0] rd_raw;
  hetq_pkg::entry_t         q;

  // Output register control.
  logic                     can_emit;
  logic                     out_load;
  logic                     out_last;

  // Derived values.
  logic                     in_acc;
  logic                     full;
  logic [DL_W:0]            tick_sum;
  logic [DL_W-1:0]          amt_sat;
  logic [PTR_W-1:0]         parent;
  logic [IDX_W-1:0]         c1;
  logic [IDX_W-1:0]         c2;
  logic [IDX_W-1:0]         count_ext;
  logic [CNT_W-1:0]         cnt_dec;
  logic                     expired;
  logic                     pop_go;
  logic                     pop_done;

  hetq_ram #(
    .WIDTH (hetq_pkg::ENTRY_W),
    .DEPTH (hetq_pkg::CAPACITY)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign q = hetq_pkg::entry_t'(rd_raw);

  // Handshake and arithmetic helpers.
  assign in_ready  = (state == hetq_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count >= CNT_W'(hetq_pkg::CAPACITY));
  assign can_emit  = !out_valid || out_ready;
  assign tick_sum  = {1'b0, tick} + (DL_W + 1)'(amount);
  assign amt_sat   = tick_sum[DL_W] ? {DL_W{1'b1}} : tick_sum[DL_W-1:0];
  assign parent    = (pos - PTR_W'(1)) >> 1;
  assign c1        = {1'b0, pos, 1'b1};
  assign c2        = c1 + IDX_W'(1);
  assign count_ext = IDX_W'(count);
  assign cnt_dec   = count - CNT_W'(1);
  assign expired   = (q.dl <= tick);
  assign pop_go    = expired && ((popped == '0) || can_emit);
  assign pop_done  = (count == '0) || (popped == POP_W'(hetq_pkg::MAX_RESULTS));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      hetq_pkg::S_IDLE: begin
        if (in_acc) begin
          if (command == hetq_pkg::CMD_ADVANCE) begin
            state_next = hetq_pkg::S_POP_RD;
          end else if (full) begin
            state_next = hetq_pkg::S_EMIT;
          end else if (count == '0) begin
            state_next = hetq_pkg::S_UP_PUT;
          end else begin
            state_next = hetq_pkg::S_UP_RD;
          end
        end
      end
      hetq_pkg::S_UP_RD:  state_next = hetq_pkg::S_UP_CMP;
      hetq_pkg::S_UP_CMP: begin
        if (entry_less(mov, q) && (parent != '0)) begin
          state_next = hetq_pkg::S_UP_RD;
        end else begin
          state_next = hetq_pkg::S_UP_PUT;
        end
      end
      hetq_pkg::S_UP_PUT: state_next = hetq_pkg::S_EMIT;
      hetq_pkg::S_EMIT: begin
        if (can_emit) begin
          state_next = hetq_pkg::S_IDLE;
        end
      end
      hetq_pkg::S_POP_RD: begin
        state_next = pop_done ? hetq_pkg::S_EMIT : hetq_pkg::S_POP_CHK;
      end
      hetq_pkg::S_POP_CHK: begin
        if (!expired) begin
          state_next = hetq_pkg::S_EMIT;
        end else if (pop_go) begin
          state_next = (count == CNT_W'(1)) ? hetq_pkg::S_POP_RD : hetq_pkg::S_POP_LAST;
        end
      end
      hetq_pkg::S_POP_LAST: state_next = hetq_pkg::S_DN_RDL;
      hetq_pkg::S_DN_RDL: begin
        state_next = (c1 < count_ext) ? hetq_pkg::S_DN_RDR : hetq_pkg::S_DN_PUT;
      end
      hetq_pkg::S_DN_RDR: begin
        state_next = (c2 < count_ext) ? hetq_pkg::S_DN_CMPR : hetq_pkg::S_DN_CMP;
      end
      hetq_pkg::S_DN_CMPR: state_next = hetq_pkg::S_DN_CMP;
      hetq_pkg::S_DN_CMP: begin
        state_next = entry_less(cand, mov) ? hetq_pkg::S_DN_RDL : hetq_pkg::S_DN_PUT;
      end
      hetq_pkg::S_DN_PUT: state_next = hetq_pkg::S_POP_RD;
      default:            state_next = hetq_pkg::S_IDLE;
    endcase
  end

  // Memory port and output register control per state.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_data  = mov;
    rd_en    = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    out_last = 1'b0;
    case (state)
      hetq_pkg::S_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      hetq_pkg::S_UP_CMP: begin
        if (entry_less(mov, q)) begin
          wr_en   = 1'b1;
          wr_data = q;
        end
      end
      hetq_pkg::S_UP_PUT: wr_en = 1'b1;
      hetq_pkg::S_EMIT: begin
        out_load = can_emit;
        out_last = 1'b1;
      end
      hetq_pkg::S_POP_RD: begin
        rd_en = !pop_done;
      end
      hetq_pkg::S_POP_CHK: begin
        // Hold the root read while stalled, else fetch the last entry.
        rd_en    = 1'b1;
        rd_addr  = pop_go ? cnt_dec[PTR_W-1:0] : '0;
        out_load = pop_go && (popped != '0);
      end
      hetq_pkg::S_DN_RDL: begin
        rd_en   = (c1 < count_ext);
        rd_addr = c1[PTR_W-1:0];
      end
      hetq_pkg::S_DN_RDR: begin
        rd_en   = (c2 < count_ext);
        rd_addr = c2[PTR_W-1:0];
      end
      hetq_pkg::S_DN_CMP: begin
        if (entry_less(cand, mov)) begin
          wr_en   = 1'b1;
          wr_data = cand;
        end
      end
      hetq_pkg::S_DN_PUT: wr_en = 1'b1;
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hetq_pkg::S_IDLE;
      count   <= '0;
      tick    <= '0;
      next_id <= ID_W'(1);
      popped  <= '0;
    end else begin
      state <= state_next;
      case (state)
        hetq_pkg::S_IDLE: begin
          if (in_acc) begin
            if (command == hetq_pkg::CMD_ADVANCE) begin
              tick   <= amt_sat;
              popped <= '0;
            end else if (!full) begin
              count   <= count + CNT_W'(1);
              next_id <= next_id + ID_W'(1);
            end
          end
        end
        hetq_pkg::S_POP_CHK: begin
          if (pop_go) begin
            count  <= cnt_dec;
            popped <= popped + POP_W'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Datapath registers: moving entry, sift position, candidate child, pending result.
  always_ff @(posedge clk) begin
    case (state)
      hetq_pkg::S_IDLE: begin
        if (in_acc && (command == hetq_pkg::CMD_ADD)) begin
          mov.dl <= amt_sat;
          mov.id <= next_id;
          pos    <= count[PTR_W-1:0];
          if (full) begin
            res_status <= hetq_pkg::ST_REJECTED;
            res_id     <= '0;
            res_dl     <= '0;
            res_count  <= count_sat(count);
          end else begin
            res_status <= hetq_pkg::ST_ADDED;
            res_id     <= next_id;
            res_dl     <= amt_sat;
            res_count  <= count_sat(count + CNT_W'(1));
          end
        end
      end
      hetq_pkg::S_UP_CMP: begin
        if (entry_less(mov, q)) begin
          pos <= parent;
        end
      end
      hetq_pkg::S_POP_RD: begin
        if (pop_done && (popped == '0)) begin
          res_status <= hetq_pkg::ST_NONE;
          res_id     <= '0;
          res_dl     <= tick;
          res_count  <= count_sat(count);
        end
      end
      hetq_pkg::S_POP_CHK: begin
        if (!expired && (popped == '0)) begin
          res_status <= hetq_pkg::ST_NONE;
          res_id     <= '0;
          res_dl     <= tick;
          res_count  <= count_sat(count);
        end else if (pop_go) begin
          res_status <= hetq_pkg::ST_EXPIRED;
          res_id     <= q.id;
          res_dl     <= q.dl;
          res_count  <= count_sat(cnt_dec);
        end
      end
      hetq_pkg::S_POP_LAST: begin
        mov <= q;
        pos <= '0;
      end
      hetq_pkg::S_DN_RDR: begin
        cand <= q;
        cidx <= c1[PTR_W-1:0];
      end
      hetq_pkg::S_DN_CMPR: begin
        if (entry_less(q, cand)) begin
          cand <= q;
          cidx <= cidx + PTR_W'(1);
        end
      end
      hetq_pkg::S_DN_CMP: begin
        if (entry_less(cand, mov)) begin
          pos <= cidx;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      event_id     <= res_id;
      deadline     <= res_dl;
      active_count <= res_count;
      last         <= out_last;
    end
  end

  // The entry count never passes the heap size.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(hetq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Every heap write lands inside the occupied region.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (IDX_W'(wr_addr) < count_ext))
    else $error("heap write outside occupied slots");

  // The root is only checked while the heap holds an entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == hetq_pkg::S_POP_CHK) |-> (count != '0))
    else $error("root check on empty heap");

  // One advance never reports more than the pop limit.
  assert property (@(posedge clk) disable iff (rst)
    popped <= POP_W'(hetq_pkg::MAX_RESULTS))
    else $error("pop limit exceeded");

  // A loaded output register never overwrites a result that was not taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[tb/heap_event_timer_queue_test.sv]
// Self-checking testbench for the heap event timer queue: random add and advance items.
`timescale 1ns / 1ps

module heap_event_timer_queue_test;

  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 410;

  // One result as the block reports it.
  typedef struct packed {
    hetq_pkg::status_t         st;
    logic [hetq_pkg::ID_W-1:0] id;
    logic [hetq_pkg::DL_W-1:0] dl;
    logic [5:0]                cnt;
    logic                      lst;
  } timer_result_t;

  // Predicts the results of each accepted item and checks the block against them.
  class event_heap_model;
    hetq_pkg::entry_t          slots[hetq_pkg::CAPACITY];
    int unsigned               count;
    logic [hetq_pkg::DL_W-1:0] tick;
    logic [hetq_pkg::ID_W-1:0] next_id;
    timer_result_t             due_results[$];
    int                        failures;

    function new();
      count    = 0;
      tick     = '0;
      next_id  = 16'd1;
      failures = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Earlier deadline first; on a tie the smaller raw id wins.
    function bit key_before(hetq_pkg::entry_t a, hetq_pkg::entry_t b);
      return {a.dl, a.id} < {b.dl, b.id};
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      hetq_pkg::entry_t t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) >> 1;
        if (!key_before(slots[pos], slots[parent])) break;
        swap_slots(pos, parent);
        pos = parent;
      end
    endfunction

    function void sift_down(int unsigned pos);
      int unsigned child;
      while (2 * pos + 1 < count) begin
        child = 2 * pos + 1;
        if (child + 1 < count && key_before(slots[child + 1], slots[child])) child = child + 1;
        if (!key_before(slots[child], slots[pos])) break;
        swap_slots(pos, child);
        pos = child;
      end
    endfunction

    function void push_result(hetq_pkg::status_t st, logic [hetq_pkg::ID_W-1:0] id,
                              logic [hetq_pkg::DL_W-1:0] dl, logic lst);
      timer_result_t r;
      r.st  = st;
      r.id  = id;
      r.dl  = dl;
      r.cnt = (count > 63) ? 6'd63 : 6'(count);
      r.lst = lst;
      due_results.push_back(r);
    endfunction

    // Updates the heap for one accepted item and queues the results it causes.
    function void apply_command(logic cmd, logic [hetq_pkg::AMT_W-1:0] amt);
      logic [hetq_pkg::DL_W:0] sum;
      hetq_pkg::entry_t        top;
      int                      popped;
      popped = 0;
      sum    = {1'b0, tick} + amt;
      if (cmd == hetq_pkg::CMD_ADD) begin
        if (count >= hetq_pkg::CAPACITY) begin
          push_result(hetq_pkg::ST_REJECTED, '0, '0, 1'b1);
        end else begin
          slots[count].dl = sum[hetq_pkg::DL_W] ? '1 : sum[hetq_pkg::DL_W-1:0];
          slots[count].id = next_id;
          top     = slots[count];
          next_id = next_id + 16'd1;
          count++;
          sift_up(count - 1);
          push_result(hetq_pkg::ST_ADDED, top.id, top.dl, 1'b1);
        end
      end else begin
        tick = sum[hetq_pkg::DL_W] ? '1 : sum[hetq_pkg::DL_W-1:0];
        while (popped < hetq_pkg::MAX_RESULTS && count > 0 && slots[0].dl <= tick) begin
          top = slots[0];
          count--;
          slots[0] = slots[count];
          sift_down(0);
          popped++;
          push_result(hetq_pkg::ST_EXPIRED, top.id, top.dl,
                      popped == hetq_pkg::MAX_RESULTS || count == 0 || slots[0].dl > tick);
        end
        if (popped == 0) push_result(hetq_pkg::ST_NONE, '0, tick, 1'b1);
      end
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void compare_result(logic [1:0] st, logic [hetq_pkg::ID_W-1:0] id,
                                 logic [hetq_pkg::DL_W-1:0] dl, logic [5:0] cnt, logic lst);
      timer_result_t e;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result: status %0d id %0d deadline %0d count %0d last %0b",
                   $realtime, st, id, dl, cnt, lst);
        return;
      end
      e = due_results.pop_front();
      if (e.st !== st || e.id !== id || e.dl !== dl || e.cnt !== cnt || e.lst !== lst) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: result mismatch: expected status %0d id %0d deadline %0d count %0d last %0b",
                   $realtime, e.st, e.id, e.dl, e.cnt, e.lst);
          $display("%0t: result mismatch: got status %0d id %0d deadline %0d count %0d last %0b",
                   $realtime, st, id, dl, cnt, lst);
        end
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic                              command;
  logic [hetq_pkg::AMT_W-1:0]        amount;
  logic                              out_valid;
  logic                              out_ready;
  logic [1:0]                        status;
  logic [hetq_pkg::ID_W-1:0]         event_id;
  logic [hetq_pkg::DL_W-1:0]         deadline;
  logic [hetq_pkg::CNT_OUT_W-1:0]    active_count;
  logic                              last;

  event_heap_model   model;
  bit                idling_on;
  int                cycle_count;

  heap_event_timer_queue uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .event_id     (event_id),
    .deadline     (deadline),
    .active_count (active_count),
    .last         (last)
  );

  // Free-running clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive all inputs to known values before the first edge.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = hetq_pkg::CMD_ADD;
    amount    = '0;
    out_ready = 1'b0;
    idling_on = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("heap_event_timer_queue test failed");
      $finish;
    end
  end

  // Check every result the moment it is accepted.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      model.compare_result(status, event_id, deadline, active_count, last);
    end
  end

  // The receiver stalls in bursts of random length while idling is on.
  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 9) == 0) begin
        stall     = $urandom_range(1, 19);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Presents one item, with an optional gap before it, and waits until it is taken.
  task automatic send_item(input logic cmd, input logic [hetq_pkg::AMT_W-1:0] amt);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    amount   = amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.apply_command(cmd, amt);
  endtask

  // Durations mostly short so that events stay pending a while, sometimes the full range.
  function automatic logic [hetq_pkg::AMT_W-1:0] pick_duration();
    return ($urandom_range(0, 4) == 0) ? hetq_pkg::AMT_W'($urandom)
                                       : hetq_pkg::AMT_W'($urandom_range(0, 300));
  endfunction

  function automatic logic [hetq_pkg::AMT_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return hetq_pkg::AMT_W'($urandom);
      default: return hetq_pkg::AMT_W'($urandom_range(1, 150));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int span;
    int add_pct;
    model       = new();
    cycle_count = 0;
    repeat (7) @(negedge clk);
    rst       = 1'b0;
    idling_on = 1'b1;

    // Directed part: empty advance, zero and maximum durations, ties on deadline,
    // expiry exactly at the tick, and alternating bit patterns.
    send_item(hetq_pkg::CMD_ADVANCE, 16'd0);
    send_item(hetq_pkg::CMD_ADD, 16'd0);
    send_item(hetq_pkg::CMD_ADD, 16'hFFFF);
    send_item(hetq_pkg::CMD_ADD, 16'd0);
    send_item(hetq_pkg::CMD_ADVANCE, 16'd0);
    send_item(hetq_pkg::CMD_ADVANCE, 16'hFFFF);
    send_item(hetq_pkg::CMD_ADVANCE, 16'd1);
    send_item(hetq_pkg::CMD_ADD, 16'd5);
    send_item(hetq_pkg::CMD_ADD, 16'd5);
    send_item(hetq_pkg::CMD_ADD, 16'd3);
    send_item(hetq_pkg::CMD_ADD, 16'd10);
    send_item(hetq_pkg::CMD_ADVANCE, 16'd4);
    send_item(hetq_pkg::CMD_ADVANCE, 16'd1);
    send_item(hetq_pkg::CMD_ADVANCE, 16'd10);
    send_item(hetq_pkg::CMD_ADD, 16'h8000);
    send_item(hetq_pkg::CMD_ADD, 16'h7FFF);
    send_item(hetq_pkg::CMD_ADD, 16'hAAAA);
    send_item(hetq_pkg::CMD_ADD, 16'h5555);
    send_item(hetq_pkg::CMD_ADVANCE, 16'hFFFF);

    // Random part in episodes of varying add density, so the heap both fills up
    // to rejection and drains; idling is switched off for some episodes.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      span      = $urandom_range(10, 40);
      add_pct   = (($urandom_range(0, 3) + 1) * 25) - 5;
      idling_on = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        if ($urandom_range(0, 99) < add_pct) send_item(hetq_pkg::CMD_ADD, pick_duration());
        else send_item(hetq_pkg::CMD_ADVANCE, pick_step());
        sent++;
      end
      // Once, let the block drain completely before going on.
      if (sent >= RANDOM_ITEMS / 2 && sent - span < RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (model.pending() != 0) @(posedge clk);
      end
    end

    // Last part, no idling: bursts of adds, each burst followed by one advance.
    idling_on = 1'b0;
    repeat (4) begin
      repeat ($urandom_range(3, 8)) send_item(hetq_pkg::CMD_ADD, pick_duration());
      send_item(hetq_pkg::CMD_ADVANCE, pick_step());
    end

    // Wait for all outstanding results, then a little longer for strays.
    @(negedge clk);
    in_valid = 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (model.failures == 0) begin
      $display("heap_event_timer_queue test passed");
    end else begin
      $display("heap_event_timer_queue test failed");
    end
    $finish;
  end

endmodule
